>>> hdl/mhfs_pkg.sv
package mhfs_pkg;

    // Fixed timing of the homing sequence, in 1 ms ticks
    localparam int unsigned FAULT_REHOME_TICKS = 5000;
    localparam int unsigned PROBE_OFF_TICKS    = 10;
    localparam int unsigned PROBE_ON_TICKS     = 100;

    localparam int unsigned TIMER_W = 17;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX       = '1;
    localparam logic [TIMER_W-1:0] PROBE_OFF_END   = TIMER_W'(PROBE_OFF_TICKS);
    localparam logic [TIMER_W-1:0] PROBE_ON_END    = TIMER_W'(PROBE_OFF_TICKS + PROBE_ON_TICKS);
    localparam logic [TIMER_W-1:0] FAULT_REHOME_AT = TIMER_W'(FAULT_REHOME_TICKS);
    localparam bit                 REHOME_ENABLED  = (FAULT_REHOME_TICKS != 0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_POSITION    = 2'd0,
        CFG_HOMING_TIME     = 2'd1,
        CFG_HOME_ON_MESSAGE = 2'd2,
        CFG_AUTO_HOME_DELAY = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_HOME     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        MODE_INIT      = 3'd0,
        MODE_PROBE_OFF = 3'd1,
        MODE_PROBE_ON  = 3'd2,
        MODE_WAIT      = 3'd3,
        MODE_NORMAL    = 3'd4,
        MODE_FAULT     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_SHORT     = 3'd2,
        ST_NO_MOTOR  = 3'd3,
        ST_REJECTED  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]       kind;
        logic             feedback_active;
        logic [POS_W-1:0] position;
        logic             allow_home;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              status;
        logic [2:0]              mode;
        logic                    drive_enable;
        logic                    move_valid;
        logic [POS_W-1:0]        target_position;
        logic signed [POS_W-1:0] position_delta;
        logic                    zero_position;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0] max_position;
        logic [CFG_W-1:0] homing_time;
        logic             home_on_message;
        logic [CFG_W-1:0] auto_home_delay;
    } t_cfg;

endpackage

>>> hdl/mhfs_in_if.sv
interface mhfs_in_if import mhfs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/mhfs_out_if.sv
interface mhfs_out_if import mhfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/motor_homing_fault_supervisor_unit.sv
// Servo drive homing and fault supervisor. Each input beat is a 1 ms tick
// (with the sampled feedback line), a position message or a home request, and
// each one yields exactly one result beat carrying the status, the mode and
// enable level after the beat, an optional clamped target move with its
// signed delta, and a zero-position strobe when homing completes. Homing
// drops enable, checks that feedback is off 10 ticks in, raises enable and
// checks feedback is on 100 ticks later, then waits until the tick count
// since homing began exceeds homing_time before going to normal mode. The
// block takes one beat per cycle while its input is not stalled: a beat goes
// through an input register, combinational decode and state update, and a
// result register. While a finished result waits, one more beat is taken
// into the input register; after that the input stalls until the result is
// taken. Write the configuration registers only while no beat is in flight.
module motor_homing_fault_supervisor_unit import mhfs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mhfs_in_if.sink              i_in_ch,
    mhfs_out_if.source           o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // Configuration registers
    t_cfg r_cfg;

    // Input stage
    logic      r_in_valid;
    t_in_item  r_in;

    // Result stage
    logic      r_out_valid;
    t_out_item r_out;

    t_out_item result;
    logic      advance;

    // Move the held beat into the result register whenever that slot is free
    // or being emptied this cycle.
    assign advance       = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || advance;

    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_position    <= POS_W'(65535);
            r_cfg.homing_time     <= CFG_W'(5000);
            r_cfg.home_on_message <= 1'b1;
            r_cfg.auto_home_delay <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_POSITION:    r_cfg.max_position    <= i_cfg_wdata;
                CFG_HOMING_TIME:     r_cfg.homing_time     <= i_cfg_wdata;
                CFG_HOME_ON_MESSAGE: r_cfg.home_on_message <= i_cfg_wdata[0];
                CFG_AUTO_HOME_DELAY: r_cfg.auto_home_delay <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold the accepted beat until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in <= i_in_ch.payload;
        end
    end

    mhfs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register: load on advance, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

endmodule

>>> hdl/mhfs_core.sv
module mhfs_core import mhfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_mode              r_mode,   n_mode;
    logic [TIMER_W-1:0] r_timer,  n_timer;
    logic [POS_W-1:0]   r_prev,   n_prev;
    logic               r_enable, n_enable;

    logic [TIMER_W-1:0] timer_inc;
    logic [POS_W-1:0]   clamped;
    logic               probe_off_due, probe_on_due, wait_due, auto_due;
    logic               fault_aged, msg_home, homing_busy;
    t_kind              kind;
    t_status            status;
    logic               move, zero;

    assign kind      = t_kind'(i_item.kind);
    assign timer_inc = (r_timer == TIMER_MAX) ? r_timer : r_timer + 1'b1;
    assign clamped   = (i_item.position > i_cfg.max_position) ? i_cfg.max_position
                                                              : i_item.position;

    assign probe_off_due = (timer_inc >= PROBE_OFF_END);
    assign probe_on_due  = (timer_inc >= PROBE_ON_END);
    assign wait_due      = (timer_inc > {1'b0, i_cfg.homing_time});
    assign auto_due      = (i_cfg.auto_home_delay != '0) &&
                           (timer_inc > {1'b0, i_cfg.auto_home_delay});
    assign fault_aged    = REHOME_ENABLED && (r_mode == MODE_FAULT) &&
                           (r_timer >= FAULT_REHOME_AT);
    assign msg_home      = i_item.allow_home && i_cfg.home_on_message &&
                           ((r_mode == MODE_INIT) || fault_aged);
    assign homing_busy   = (r_mode == MODE_PROBE_OFF) || (r_mode == MODE_PROBE_ON) ||
                           (r_mode == MODE_WAIT);

    // Next state
    always_comb begin
        n_mode   = r_mode;
        n_timer  = r_timer;
        n_enable = r_enable;
        n_prev   = r_prev;
        unique case (kind)
            KIND_TICK: begin
                n_timer = timer_inc;
                unique case (r_mode)
                    MODE_INIT: begin
                        if (auto_due) begin
                            n_mode   = MODE_PROBE_OFF;
                            n_timer  = '0;
                            n_enable = 1'b0;
                        end
                    end
                    MODE_PROBE_OFF: begin
                        if (probe_off_due) begin
                            if (i_item.feedback_active) begin
                                n_mode = MODE_FAULT;
                            end else begin
                                n_mode   = MODE_PROBE_ON;
                                n_enable = 1'b1;
                            end
                        end
                    end
                    MODE_PROBE_ON: begin
                        if (probe_on_due) begin
                            if (!i_item.feedback_active) begin
                                n_mode   = MODE_FAULT;
                                n_enable = 1'b0;
                            end else begin
                                n_mode = MODE_WAIT;
                            end
                        end
                    end
                    MODE_WAIT: begin
                        if (wait_due) begin
                            n_mode = MODE_NORMAL;
                        end
                    end
                    MODE_NORMAL: begin
                        if (!i_item.feedback_active) begin
                            n_mode   = MODE_FAULT;
                            n_enable = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_POSITION: begin
                if (msg_home) begin
                    n_mode   = MODE_PROBE_OFF;
                    n_timer  = '0;
                    n_enable = 1'b0;
                end else if (r_mode == MODE_NORMAL) begin
                    n_prev = clamped;
                end
            end
            KIND_HOME: begin
                if (!homing_busy) begin
                    n_mode   = MODE_PROBE_OFF;
                    n_timer  = '0;
                    n_enable = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Result flags
    always_comb begin
        status = ST_OK;
        move   = 1'b0;
        zero   = 1'b0;
        unique case (kind)
            KIND_TICK: begin
                unique case (r_mode)
                    MODE_PROBE_OFF: begin
                        if (probe_off_due && i_item.feedback_active) begin
                            status = ST_SHORT;
                        end
                    end
                    MODE_PROBE_ON: begin
                        if (probe_on_due && !i_item.feedback_active) begin
                            status = ST_NO_MOTOR;
                        end
                    end
                    MODE_WAIT: begin
                        zero = wait_due;
                    end
                    default: ;
                endcase
            end
            KIND_POSITION: begin
                if (!msg_home) begin
                    if (r_mode != MODE_NORMAL) begin
                        status = ST_REJECTED;
                    end else begin
                        move = 1'b1;
                    end
                end
            end
            KIND_HOME: begin
                if (homing_busy) begin
                    status = ST_BUSY;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.status          = status;
        o_result.mode            = n_mode;
        o_result.drive_enable    = n_enable;
        o_result.move_valid      = move;
        o_result.target_position = move ? clamped : r_prev;
        o_result.position_delta  = move ? $signed(clamped - r_prev) : '0;
        o_result.zero_position   = zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_INIT;
            r_timer  <= '0;
            r_prev   <= '0;
            r_enable <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_timer  <= n_timer;
            r_prev   <= n_prev;
            r_enable <= n_enable;
        end
    end

endmodule

>>> hdl/mhfs_checker.sv
module mhfs_checker import mhfs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Homing completes into normal mode with the drive enabled
    a_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out.zero_position) |->
            (i_out.mode == MODE_NORMAL && i_out.drive_enable))
        else $error("zero strobe outside homing completion");

    // Moves are issued only in normal mode, without error status
    a_move_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out.move_valid) |->
            (i_out.mode == MODE_NORMAL && i_out.status == ST_OK))
        else $error("move issued outside normal mode");

    // A short fault leaves the drive disabled in fault mode
    a_short_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out.status == ST_SHORT) |->
            (i_out.mode == MODE_FAULT && !i_out.drive_enable))
        else $error("short fault without disabled fault mode");

endmodule

bind motor_homing_fault_supervisor_unit mhfs_checker u_mhfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out       (o_out_ch.payload)
);
